[design/chgs_pkg.sv]
// ----------------------------------------------------------------------------
// chgs_pkg
// shared codes and types for the convex hull graham scan unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package chgs_pkg;

  typedef logic [1:0] turn_t;
  typedef logic [1:0] status_t;

  localparam turn_t TURN_COL = 2'd0;
  localparam turn_t TURN_CW  = 2'd1;
  localparam turn_t TURN_CCW = 2'd2;

  localparam status_t STAT_VERTEX = 2'd0;
  localparam status_t STAT_NONE   = 2'd1;
  localparam status_t STAT_SINGLE = 2'd2;

  localparam int MIN_HULL = 3;

  typedef struct packed {
    logic  done;
    turn_t turn;
  } turn_rsp_t;

endpackage

[design/chgs_if.sv]
// ----------------------------------------------------------------------------
// chgs_if
// point input and hull vertex output channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface chgs_in_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_z;
  logic                         last_point;

  modport source (output valid, output coord_x, output coord_z, output last_point,
                  input ready);
  modport sink (input valid, input coord_x, input coord_z, input last_point,
                output ready);
endinterface

interface chgs_out_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] hull_x;
  logic signed [COORD_BITS-1:0] hull_z;
  logic [1:0]                   hull_status;
  logic                         overflowed;
  logic                         last_vertex;

  modport source (output valid, output hull_x, output hull_z, output hull_status,
                  output overflowed, output last_vertex, input ready);
  modport sink (input valid, input hull_x, input hull_z, input hull_status,
                input overflowed, input last_vertex, output ready);
endinterface

[design/chgs_turn.sv]
// ----------------------------------------------------------------------------
// chgs_turn
// orientation of a -> b -> c through one shared multiplier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chgs_turn
  import chgs_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] az,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] bz,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cz,
  output turn_rsp_t                    rsp
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic [1:0]           step_r, step_nxt;
  logic signed [DW-1:0] d1_r, d2_r, d3_r, d4_r;
  logic signed [PW-1:0] lhs_r;
  turn_t                res_r;
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;

  assign mul_a = (step_r == 2'd1) ? d1_r : d3_r;
  assign mul_b = (step_r == 2'd1) ? d2_r : d4_r;
  assign prod  = mul_a * mul_b;

  always_comb begin
    step_nxt = step_r;
    case (step_r)
      2'd0: if (start) step_nxt = 2'd1;
      2'd1: step_nxt = 2'd2;
      2'd2: step_nxt = 2'd3;
      default: step_nxt = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 2'd0;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_r == 2'd0 && start) begin
      d1_r <= DW'(bz) - DW'(az);
      d2_r <= DW'(cx) - DW'(bx);
      d3_r <= DW'(bx) - DW'(ax);
      d4_r <= DW'(cz) - DW'(bz);
    end
    if (step_r == 2'd1) lhs_r <= prod;
    if (step_r == 2'd2) begin
      if (lhs_r == prod)     res_r <= TURN_COL;
      else if (lhs_r > prod) res_r <= TURN_CW;
      else                   res_r <= TURN_CCW;
    end
  end

  assign rsp.done = (step_r == 2'd3);
  assign rsp.turn = res_r;

endmodule

[design/convex_hull_graham_scan_unit.sv]
// ----------------------------------------------------------------------------
// convex_hull_graham_scan_unit
// sequence: points load one per cycle; after the last point the pivot search reads
//   each point, the insertion sort shifts each point into place, and the collinear
//   pass and stack scan step per point or pop, all paced by the single orientation
//   unit and the point memory, which has one read port
// throughput: one hull set at a time; each vertex word needs a stack read, a point read
// reset: sync active-low rst_n clears sequencer, point count, overflow and output valid
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module convex_hull_graham_scan_unit
  import chgs_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input logic          clk,
  input logic          rst_n,
  chgs_in_if.sink      in_bus,
  chgs_out_if.source   out_bus
);

  localparam int CB = COORD_BITS;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int IW = $clog2(MAX_POINTS);

  localparam logic [5:0] S_IDLE = 6'd0,  S_PV_RD = 6'd1,  S_PV_CMP = 6'd2,
                         S_SW_RD = 6'd3, S_SW_W1 = 6'd4,  S_SW_W2 = 6'd5,
                         S_SO_RDI = 6'd6, S_SO_LDI = 6'd7, S_SO_CHK = 6'd8,
                         S_SO_LDP = 6'd9, S_SO_GO = 6'd10, S_SO_WAIT = 6'd11,
                         S_SO_WR = 6'd12, S_DD_RD = 6'd13, S_DD_LD = 6'd14,
                         S_DD_CHK = 6'd15, S_DD_LDN = 6'd16, S_DD_GO = 6'd17,
                         S_DD_WAIT = 6'd18, S_DD_END = 6'd19, S_SC_I0 = 6'd20,
                         S_SC_I1 = 6'd21, S_SC_I2 = 6'd22, S_SC_CHK = 6'd23,
                         S_SC_LDC = 6'd24, S_SC_GO = 6'd25, S_SC_WAIT = 6'd26,
                         S_SC_PS = 6'd27, S_SC_PM = 6'd28, S_EM_RS = 6'd29,
                         S_EM_RM = 6'd30, S_EM_LD = 6'd31, S_ONE = 6'd32;

  // point and stack memories
  logic [2*CB-1:0] pt_mem [MAX_POINTS];
  logic [IW-1:0]   stk_mem [MAX_POINTS];
  logic [2*CB-1:0] pt_rdata, pt_wdata;
  logic [IW-1:0]   pt_raddr, pt_waddr, stk_raddr, stk_waddr, stk_rdata, stk_wdata;
  logic            pt_re, pt_we, stk_re, stk_we;

  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[pt_waddr] <= pt_wdata;
    if (pt_re) pt_rdata <= pt_mem[pt_raddr];
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (stk_re) stk_rdata <= stk_mem[stk_raddr];
  end

  logic [5:0]           state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt, n_r, n_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [CW-1:0]        m_r, m_nxt, k_r, k_nxt, sd_r, sd_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [IW-1:0]        piv_idx_r, piv_idx_nxt;
  logic signed [CB-1:0] piv_x_r, piv_x_nxt, piv_z_r, piv_z_nxt;
  logic signed [CB-1:0] ra_x_r, ra_x_nxt, ra_z_r, ra_z_nxt;
  logic signed [CB-1:0] rb_x_r, rb_x_nxt, rb_z_r, rb_z_nxt;
  logic signed [CB-1:0] rc_x_r, rc_x_nxt, rc_z_r, rc_z_nxt;
  status_t              one_stat_r, one_stat_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic signed [CB-1:0] hull_x_r, hull_x_nxt, hull_z_r, hull_z_nxt;
  status_t              hull_status_r, hull_status_nxt;
  logic                 ovfl_out_r, ovfl_out_nxt, last_r, last_nxt;

  logic                 turn_start;
  turn_rsp_t            turn_rsp;
  logic signed [CB-1:0] rd_x, rd_z;
  logic                 out_free, in_acc;
  logic signed [CB:0]   dbx, dbz, dcx, dcz;
  logic [CB+1:0]        l1_b, l1_c;
  logic                 ahead;

  chgs_turn #(.COORD_BITS(CB)) u_turn (
    .clk   (clk),
    .rst_n (rst_n),
    .start (turn_start),
    .ax    (ra_x_r),
    .az    (ra_z_r),
    .bx    (rb_x_r),
    .bz    (rb_z_r),
    .cx    (rc_x_r),
    .cz    (rc_z_r),
    .rsp   (turn_rsp)
  );

  assign rd_x     = pt_rdata[2*CB-1:CB];
  assign rd_z     = pt_rdata[CB-1:0];
  assign out_free = !out_valid_r || out_bus.ready;
  assign in_acc   = in_bus.valid && in_bus.ready;
  assign in_bus.ready = (state_r == S_IDLE);

  // manhattan distance from the pivot, exact order along one ray
  always_comb begin
    dbx  = (CB+1)'(rb_x_r) - (CB+1)'(ra_x_r);
    dbz  = (CB+1)'(rb_z_r) - (CB+1)'(ra_z_r);
    dcx  = (CB+1)'(rc_x_r) - (CB+1)'(ra_x_r);
    dcz  = (CB+1)'(rc_z_r) - (CB+1)'(ra_z_r);
    l1_b = (CB+2)'(dbx[CB] ? -dbx : dbx) + (CB+2)'(dbz[CB] ? -dbz : dbz);
    l1_c = (CB+2)'(dcx[CB] ? -dcx : dcx) + (CB+2)'(dcz[CB] ? -dcz : dcz);
    ahead = (turn_rsp.turn == TURN_CCW) || ((turn_rsp.turn == TURN_COL) && (l1_b < l1_c));
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;  n_nxt = n_r;  i_nxt = i_r;  j_nxt = j_r;
    m_nxt = m_r;  k_nxt = k_r;  sd_nxt = sd_r;  ovf_nxt = ovf_r;
    piv_idx_nxt = piv_idx_r;  piv_x_nxt = piv_x_r;  piv_z_nxt = piv_z_r;
    ra_x_nxt = ra_x_r;  ra_z_nxt = ra_z_r;  rb_x_nxt = rb_x_r;  rb_z_nxt = rb_z_r;
    rc_x_nxt = rc_x_r;  rc_z_nxt = rc_z_r;  one_stat_nxt = one_stat_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    hull_x_nxt = hull_x_r;  hull_z_nxt = hull_z_r;  hull_status_nxt = hull_status_r;
    ovfl_out_nxt = ovfl_out_r;  last_nxt = last_r;
    pt_re = 1'b0;  pt_raddr = '0;  pt_we = 1'b0;  pt_waddr = '0;  pt_wdata = '0;
    stk_re = 1'b0;  stk_raddr = '0;  stk_we = 1'b0;  stk_waddr = '0;  stk_wdata = '0;
    turn_start = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          n_nxt = cnt_r;
          if (cnt_r < CW'(MAX_POINTS)) begin
            pt_we    = 1'b1;
            pt_waddr = cnt_r[IW-1:0];
            pt_wdata = {in_bus.coord_x, in_bus.coord_z};
            cnt_nxt  = cnt_r + CW'(1);
            n_nxt    = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_bus.last_point) begin
            i_nxt     = '0;
            state_nxt = S_PV_RD;
          end
        end
      end

      // pivot search
      S_PV_RD: begin
        pt_re     = 1'b1;
        pt_raddr  = i_r[IW-1:0];
        i_nxt     = i_r + CW'(1);
        state_nxt = S_PV_CMP;
      end
      S_PV_CMP: begin
        if (i_r == CW'(1) || rd_z < piv_z_r || (rd_z == piv_z_r && rd_x < piv_x_r)) begin
          piv_x_nxt   = rd_x;
          piv_z_nxt   = rd_z;
          piv_idx_nxt = IW'(i_r - CW'(1));
        end
        state_nxt = (i_r < n_r) ? S_PV_RD : S_SW_RD;
      end
      S_SW_RD: begin
        pt_re     = 1'b1;
        pt_raddr  = '0;
        state_nxt = S_SW_W1;
      end
      S_SW_W1: begin
        pt_we     = 1'b1;
        pt_waddr  = piv_idx_r;
        pt_wdata  = pt_rdata;
        state_nxt = S_SW_W2;
      end
      S_SW_W2: begin
        pt_we    = 1'b1;
        pt_waddr = '0;
        pt_wdata = {piv_x_r, piv_z_r};
        ra_x_nxt = piv_x_r;
        ra_z_nxt = piv_z_r;
        m_nxt    = CW'(1);
        if (n_r > CW'(2)) begin
          i_nxt     = CW'(2);
          state_nxt = S_SO_RDI;
        end else if (n_r == CW'(2)) begin
          i_nxt     = CW'(1);
          state_nxt = S_DD_RD;
        end else begin
          state_nxt = S_DD_END;
        end
      end

      // insertion sort by angle around the pivot
      S_SO_RDI: begin
        pt_re     = 1'b1;
        pt_raddr  = i_r[IW-1:0];
        state_nxt = S_SO_LDI;
      end
      S_SO_LDI: begin
        rb_x_nxt  = rd_x;
        rb_z_nxt  = rd_z;
        j_nxt     = i_r;
        state_nxt = S_SO_CHK;
      end
      S_SO_CHK: begin
        if (j_r > CW'(1)) begin
          pt_re     = 1'b1;
          pt_raddr  = IW'(j_r - CW'(1));
          state_nxt = S_SO_LDP;
        end else begin
          state_nxt = S_SO_WR;
        end
      end
      S_SO_LDP: begin
        rc_x_nxt  = rd_x;
        rc_z_nxt  = rd_z;
        state_nxt = S_SO_GO;
      end
      S_SO_GO: begin
        turn_start = 1'b1;
        state_nxt  = S_SO_WAIT;
      end
      S_SO_WAIT: begin
        if (turn_rsp.done) begin
          if (ahead) begin
            pt_we     = 1'b1;
            pt_waddr  = j_r[IW-1:0];
            pt_wdata  = {rc_x_r, rc_z_r};
            j_nxt     = j_r - CW'(1);
            state_nxt = S_SO_CHK;
          end else begin
            state_nxt = S_SO_WR;
          end
        end
      end
      S_SO_WR: begin
        pt_we    = 1'b1;
        pt_waddr = j_r[IW-1:0];
        pt_wdata = {rb_x_r, rb_z_r};
        if ((i_r + CW'(1)) < n_r) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_SO_RDI;
        end else begin
          i_nxt     = CW'(1);
          state_nxt = S_DD_RD;
        end
      end

      // keep only the farthest of each run collinear with the pivot
      S_DD_RD: begin
        pt_re     = 1'b1;
        pt_raddr  = i_r[IW-1:0];
        state_nxt = S_DD_LD;
      end
      S_DD_LD: begin
        rb_x_nxt  = rd_x;
        rb_z_nxt  = rd_z;
        state_nxt = S_DD_CHK;
      end
      S_DD_CHK: begin
        if ((i_r + CW'(1)) < n_r) begin
          pt_re     = 1'b1;
          pt_raddr  = IW'(i_r + CW'(1));
          state_nxt = S_DD_LDN;
        end else begin
          pt_we     = 1'b1;
          pt_waddr  = m_r[IW-1:0];
          pt_wdata  = {rb_x_r, rb_z_r};
          m_nxt     = m_r + CW'(1);
          state_nxt = S_DD_END;
        end
      end
      S_DD_LDN: begin
        rc_x_nxt  = rd_x;
        rc_z_nxt  = rd_z;
        state_nxt = S_DD_GO;
      end
      S_DD_GO: begin
        turn_start = 1'b1;
        state_nxt  = S_DD_WAIT;
      end
      S_DD_WAIT: begin
        if (turn_rsp.done) begin
          if (turn_rsp.turn != TURN_COL) begin
            pt_we    = 1'b1;
            pt_waddr = m_r[IW-1:0];
            pt_wdata = {rb_x_r, rb_z_r};
            m_nxt    = m_r + CW'(1);
          end
          rb_x_nxt  = rc_x_r;
          rb_z_nxt  = rc_z_r;
          i_nxt     = i_r + CW'(1);
          state_nxt = S_DD_CHK;
        end
      end
      S_DD_END: begin
        if (m_r < CW'(MIN_HULL)) begin
          one_stat_nxt = STAT_NONE;
          state_nxt    = S_ONE;
        end else begin
          state_nxt = S_SC_I0;
        end
      end

      // stack scan
      S_SC_I0: begin
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = '0;
        pt_re     = 1'b1;
        pt_raddr  = IW'(1);
        state_nxt = S_SC_I1;
      end
      S_SC_I1: begin
        stk_we    = 1'b1;
        stk_waddr = IW'(1);
        stk_wdata = IW'(1);
        ra_x_nxt  = rd_x;
        ra_z_nxt  = rd_z;
        pt_re     = 1'b1;
        pt_raddr  = IW'(2);
        state_nxt = S_SC_I2;
      end
      S_SC_I2: begin
        stk_we    = 1'b1;
        stk_waddr = IW'(2);
        stk_wdata = IW'(2);
        rb_x_nxt  = rd_x;
        rb_z_nxt  = rd_z;
        sd_nxt    = CW'(3);
        i_nxt     = CW'(3);
        state_nxt = S_SC_CHK;
      end
      S_SC_CHK: begin
        if (i_r < m_r) begin
          pt_re     = 1'b1;
          pt_raddr  = i_r[IW-1:0];
          state_nxt = S_SC_LDC;
        end else begin
          k_nxt     = '0;
          state_nxt = S_EM_RS;
        end
      end
      S_SC_LDC: begin
        rc_x_nxt  = rd_x;
        rc_z_nxt  = rd_z;
        state_nxt = S_SC_GO;
      end
      S_SC_GO: begin
        turn_start = 1'b1;
        state_nxt  = S_SC_WAIT;
      end
      S_SC_WAIT: begin
        if (turn_rsp.done) begin
          if (turn_rsp.turn == TURN_CCW) begin
            stk_we    = 1'b1;
            stk_waddr = sd_r[IW-1:0];
            stk_wdata = i_r[IW-1:0];
            sd_nxt    = sd_r + CW'(1);
            ra_x_nxt  = rb_x_r;
            ra_z_nxt  = rb_z_r;
            rb_x_nxt  = rc_x_r;
            rb_z_nxt  = rc_z_r;
            i_nxt     = i_r + CW'(1);
            state_nxt = S_SC_CHK;
          end else if (sd_r == CW'(2)) begin
            one_stat_nxt = STAT_SINGLE;
            state_nxt    = S_ONE;
          end else begin
            sd_nxt    = sd_r - CW'(1);
            rb_x_nxt  = ra_x_r;
            rb_z_nxt  = ra_z_r;
            stk_re    = 1'b1;
            stk_raddr = IW'(sd_r - CW'(3));
            state_nxt = S_SC_PS;
          end
        end
      end
      S_SC_PS: begin
        pt_re     = 1'b1;
        pt_raddr  = stk_rdata;
        state_nxt = S_SC_PM;
      end
      S_SC_PM: begin
        ra_x_nxt  = rd_x;
        ra_z_nxt  = rd_z;
        state_nxt = S_SC_GO;
      end

      // vertex output
      S_EM_RS: begin
        stk_re    = 1'b1;
        stk_raddr = k_r[IW-1:0];
        state_nxt = S_EM_RM;
      end
      S_EM_RM: begin
        pt_re     = 1'b1;
        pt_raddr  = stk_rdata;
        state_nxt = S_EM_LD;
      end
      S_EM_LD: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          hull_x_nxt      = rd_x;
          hull_z_nxt      = rd_z;
          hull_status_nxt = STAT_VERTEX;
          ovfl_out_nxt    = ovf_r;
          last_nxt        = ((k_r + CW'(1)) == sd_r);
          if ((k_r + CW'(1)) == sd_r) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + CW'(1);
            state_nxt = S_EM_RS;
          end
        end
      end
      S_ONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          hull_x_nxt      = (one_stat_r == STAT_SINGLE) ? piv_x_r : '0;
          hull_z_nxt      = (one_stat_r == STAT_SINGLE) ? piv_z_r : '0;
          hull_status_nxt = one_stat_r;
          ovfl_out_nxt    = ovf_r;
          last_nxt        = 1'b1;
          cnt_nxt         = '0;
          ovf_nxt         = 1'b0;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r           <= n_nxt;
    i_r           <= i_nxt;
    j_r           <= j_nxt;
    m_r           <= m_nxt;
    k_r           <= k_nxt;
    sd_r          <= sd_nxt;
    piv_idx_r     <= piv_idx_nxt;
    piv_x_r       <= piv_x_nxt;
    piv_z_r       <= piv_z_nxt;
    ra_x_r        <= ra_x_nxt;
    ra_z_r        <= ra_z_nxt;
    rb_x_r        <= rb_x_nxt;
    rb_z_r        <= rb_z_nxt;
    rc_x_r        <= rc_x_nxt;
    rc_z_r        <= rc_z_nxt;
    one_stat_r    <= one_stat_nxt;
    hull_x_r      <= hull_x_nxt;
    hull_z_r      <= hull_z_nxt;
    hull_status_r <= hull_status_nxt;
    ovfl_out_r    <= ovfl_out_nxt;
    last_r        <= last_nxt;
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.hull_x      = hull_x_r;
  assign out_bus.hull_z      = hull_z_r;
  assign out_bus.hull_status = hull_status_r;
  assign out_bus.overflowed  = ovfl_out_r;
  assign out_bus.last_vertex = last_r;

endmodule

[bench/tb_convex_hull_graham_scan_unit.sv]
// ----------------------------------------------------------------------------
// tb_convex_hull_graham_scan_unit
// Feeds point sets to the hull unit and checks each vertex word against a
// graham scan worked out in the bench. Covers coordinate extremes, degenerate
// sets, pivot duplicates, overflow and random sets with random idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_convex_hull_graham_scan_unit;
  import chgs_pkg::*;

  localparam int NPTS = 64;
  localparam int CB   = 16;

  typedef struct {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] z;
    status_t              status;
    logic                 ovf;
    logic                 last;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   failed = 1'b0;
  bit   no_idle = 1'b0;

  chgs_in_if  #(.COORD_BITS(CB)) in_bus ();
  chgs_out_if #(.COORD_BITS(CB)) out_bus ();

  convex_hull_graham_scan_unit #(.MAX_POINTS(NPTS), .COORD_BITS(CB)) DUT (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus.sink), .out_bus(out_bus.source)
  );

  always #5 clk = ~clk;

  // bench copy of the point store
  int      pt_x [NPTS];
  int      pt_z [NPTS];
  int      pt_cnt;
  bit      pt_ovf;
  vertex_t hull_q[$];

  function automatic turn_t orient(int ax, int az, int bx, int bz, int cx, int cz);
    longint l, r;
    l = (longint'(bz) - az) * (longint'(cx) - bx);
    r = (longint'(bx) - ax) * (longint'(cz) - bz);
    if (l == r) return TURN_COL;
    return (l > r) ? TURN_CW : TURN_CCW;
  endfunction

  function automatic longint sq_dist(int ax, int az, int bx, int bz);
    longint dx, dz;
    dx = longint'(ax) - bx;
    dz = longint'(az) - bz;
    return dx * dx + dz * dz;
  endfunction

  function automatic bit angle_less(int a, int b);
    turn_t t;
    t = orient(pt_x[0], pt_z[0], pt_x[a], pt_z[a], pt_x[b], pt_z[b]);
    if (t == TURN_COL)
      return sq_dist(pt_x[0], pt_z[0], pt_x[a], pt_z[a]) <
             sq_dist(pt_x[0], pt_z[0], pt_x[b], pt_z[b]);
    return t == TURN_CCW;
  endfunction

  function automatic void swap_pts(int a, int b);
    int tx, tz;
    tx = pt_x[a]; tz = pt_z[a];
    pt_x[a] = pt_x[b]; pt_z[a] = pt_z[b];
    pt_x[b] = tx; pt_z[b] = tz;
  endfunction

  function automatic void push_vertex(int x, int z, status_t st, bit lst);
    vertex_t v;
    v.x = x[CB-1:0];
    v.z = z[CB-1:0];
    v.status = st;
    v.ovf = pt_ovf;
    v.last = lst;
    hull_q = {hull_q, v};
  endfunction

  function automatic void compute_hull();
    int n, piv, m, j, i, dep, a, b;
    int stk [NPTS];
    bit collapsed;
    n = pt_cnt;
    piv = 0;
    collapsed = 1'b0;
    for (int k = 1; k < n; k++)
      if (pt_z[k] < pt_z[piv] || (pt_z[k] == pt_z[piv] && pt_x[k] < pt_x[piv])) piv = k;
    if (n > 0) swap_pts(0, piv);
    for (int k = 2; k < n; k++) begin
      j = k;
      while (j > 1 && angle_less(j, j - 1)) begin
        swap_pts(j, j - 1);
        j--;
      end
    end
    m = 1;
    i = 1;
    while (i < n) begin
      while (i + 1 < n &&
             orient(pt_x[0], pt_z[0], pt_x[i], pt_z[i], pt_x[i+1], pt_z[i+1]) == TURN_COL)
        i++;
      pt_x[m] = pt_x[i];
      pt_z[m] = pt_z[i];
      m++;
      i++;
    end
    if (n == 0 || m < MIN_HULL) begin
      push_vertex(0, 0, STAT_NONE, 1'b1);
      return;
    end
    stk[0] = 0; stk[1] = 1; stk[2] = 2;
    dep = 3;
    for (int k = 3; k < m && !collapsed; k++) begin
      forever begin
        a = stk[dep-2];
        b = stk[dep-1];
        if (orient(pt_x[a], pt_z[a], pt_x[b], pt_z[b], pt_x[k], pt_z[k]) == TURN_CCW) break;
        dep--;
        if (dep == 1) begin
          collapsed = 1'b1;
          break;
        end
      end
      if (!collapsed) begin
        stk[dep] = k;
        dep++;
      end
    end
    if (collapsed) begin
      push_vertex(pt_x[0], pt_z[0], STAT_SINGLE, 1'b1);
      return;
    end
    for (int k = 0; k < dep; k++)
      push_vertex(pt_x[stk[k]], pt_z[stk[k]], STAT_VERTEX, k + 1 == dep);
  endfunction

  function automatic void take_point(int x, int z, bit lst);
    if (pt_cnt < NPTS) begin
      pt_x[pt_cnt] = x;
      pt_z[pt_cnt] = z;
      pt_cnt++;
    end else begin
      pt_ovf = 1'b1;
    end
    if (lst) begin
      compute_hull();
      pt_cnt = 0;
      pt_ovf = 1'b0;
    end
  endfunction

  task automatic send_point(int x, int z, bit lst);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.coord_x    <= x[CB-1:0];
    in_bus.coord_z    <= z[CB-1:0];
    in_bus.last_point <= lst;
    do @(posedge clk); while (!in_bus.ready);
    take_point(x, z, lst);
  endtask

  task automatic send_set(int xs[$], int zs[$]);
    foreach (xs[k]) send_point(xs[k], zs[k], k == xs.size() - 1);
  endtask

  function automatic int rnd_coord(int span);
    if (span == 0) return $signed(16'($urandom));
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // vertex word checker and ready driver
  initial begin
    vertex_t e;
    int stall;
    out_bus.ready = 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 11);
      repeat (stall) begin
        @(negedge clk);
        out_bus.ready <= 1'b0;
      end
      @(negedge clk);
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_bus.valid));
      if (hull_q.size() == 0) begin
        $error("unexpected word x=%0d z=%0d", out_bus.hull_x, out_bus.hull_z);
        failed = 1'b1;
      end else begin
        e = hull_q.pop_front();
        if (out_bus.hull_x !== e.x) begin
          $error("hull_x exp %0d got %0d", e.x, out_bus.hull_x); failed = 1'b1;
        end
        if (out_bus.hull_z !== e.z) begin
          $error("hull_z exp %0d got %0d", e.z, out_bus.hull_z); failed = 1'b1;
        end
        if (out_bus.hull_status !== e.status) begin
          $error("hull_status exp %0d got %0d", e.status, out_bus.hull_status); failed = 1'b1;
        end
        if (out_bus.overflowed !== e.ovf) begin
          $error("overflowed exp %0d got %0d", e.ovf, out_bus.overflowed); failed = 1'b1;
        end
        if (out_bus.last_vertex !== e.last) begin
          $error("last_vertex exp %0d got %0d", e.last, out_bus.last_vertex); failed = 1'b1;
        end
      end
    end
  end

  task automatic test_extremes();
    send_set('{-32768, 32767, 32767, -32768}, '{-32768, -32768, 32767, 32767});
  endtask

  task automatic test_degenerate();
    send_set('{5}, '{-7});
    send_set('{1, -3}, '{2, 2});
    send_set('{0, 10, 20}, '{0, 10, 20});
  endtask

  task automatic test_pivot_copies();
    send_set('{0, 0, 4, 4, 0, 2, 0}, '{0, 0, 0, 4, 4, 2, 0});
  endtask

  task automatic test_overflow();
    for (int k = 0; k < NPTS + 2; k++)
      send_point(rnd_coord(0), rnd_coord(0), k == NPTS + 1);
  endtask

  task automatic test_random_sets(int n_items);
    int sent, sz, span;
    sent = 0;
    while (sent < n_items) begin
      no_idle = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 9))
        0:       sz = $urandom_range(1, 2);
        1:       sz = $urandom_range(13, 24);
        default: sz = $urandom_range(3, 10);
      endcase
      span = ($urandom_range(0, 2) == 0) ? 3 : 0;
      for (int k = 0; k < sz; k++) send_point(rnd_coord(span), rnd_coord(span), k == sz - 1);
      sent += sz;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    in_bus.valid = 1'b0;
    in_bus.coord_x = '0;
    in_bus.coord_z = '0;
    in_bus.last_point = 1'b0;
    pt_cnt = 0;
    pt_ovf = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_degenerate();
    test_pivot_copies();
    test_overflow();
    test_random_sets(60);
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (hull_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (!failed) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #50ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
